// ===== src/mtmp_pkg.sv =====
// Shared types, codes and helpers of the MIDI track meta event parser.
`default_nettype none
package mtmp_pkg;

  localparam int unsigned TICK_OUT_W  = 32;
  localparam int unsigned TEMPO_W     = 24;
  localparam int unsigned NUMBER_W    = 32;

  localparam logic [7:0] META_PREFIX  = 8'hFF;
  localparam logic [7:0] META_TEMPO   = 8'h51;
  localparam logic [7:0] META_TIMESIG = 8'h58;
  localparam logic [7:0] META_EOT     = 8'h2F;
  localparam logic [7:0] SYSEX_START  = 8'hF0;
  localparam logic [7:0] SYSEX_ESCAPE = 8'hF7;

  localparam logic [3:0] STATUS_PROGRAM  = 4'hC;
  localparam logic [3:0] STATUS_PRESSURE = 4'hD;
  localparam logic [3:0] STATUS_SYSTEM   = 4'hF;

  localparam logic EVT_TEMPO   = 1'b0;
  localparam logic EVT_TIMESIG = 1'b1;

  typedef enum logic [2:0] {
    PH_DELTA,
    PH_STATUS,
    PH_META_TYPE,
    PH_META_LEN,
    PH_META_DATA,
    PH_SYSEX_LEN,
    PH_SKIP,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic                  event_kind;
    logic [TICK_OUT_W-1:0] tick;
    logic [TEMPO_W-1:0]    tempo_us_per_quarter;
    logic [7:0]            sig_numerator;
    logic [7:0]            sig_denominator_log2;
  } event_t;

  // Data bytes that follow a status byte.
  function automatic logic [1:0] data_count(input logic [7:0] status);
    logic [1:0] count;
    case (status[7:4]) inside
      STATUS_PROGRAM, STATUS_PRESSURE, STATUS_SYSTEM: count = 2'd1;
      default:                                        count = 2'd2;
    endcase
    return count;
  endfunction

endpackage
`default_nettype wire

// ===== src/mtmp_byte_if.sv =====
// Channel that carries track bytes into the parser.
`default_nettype none
interface mtmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       track_last;

  modport source (output valid, output data_byte, output track_last, input ready);
  modport sink (input valid, input data_byte, input track_last, output ready);
endinterface
`default_nettype wire

// ===== src/mtmp_event_if.sv =====
// Channel that carries tempo and time signature events out of the parser.
`default_nettype none
interface mtmp_event_if
  import mtmp_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic                  event_kind;
  logic [TICK_OUT_W-1:0] tick;
  logic [TEMPO_W-1:0]    tempo_us_per_quarter;
  logic [7:0]            sig_numerator;
  logic [7:0]            sig_denominator_log2;

  modport source (output valid, output event_kind, output tick, output tempo_us_per_quarter,
                  output sig_numerator, output sig_denominator_log2, input ready);
  modport sink (input valid, input event_kind, input tick, input tempo_us_per_quarter,
                input sig_numerator, input sig_denominator_log2, output ready);
endinterface
`default_nettype wire

// ===== src/midi_track_meta_event_parser_core.sv =====
// Usage notes:
// byte_in takes one byte of a MIDI track chunk body per request, with track_last
// high on the final byte of the track. event_out delivers one request per tempo
// meta event (nonzero value, length three) and per time signature meta event
// (length four), tagged with the absolute tick of the event.
// Each byte is decoded in the cycle it is accepted; its event, if any, is written to
// the output register, or to the skid register while an event there is still waiting.
// Throughput is one byte per cycle while byte_in.ready is high; the per-byte state
// update is the only loop. Results pass through an output register backed by a
// skid register, so bytes keep flowing while one event waits. Ready drops only
// while both hold an event and rises again the cycle after the receiver takes one.
// Reset (rst, synchronous) empties both registers and returns the parser to
// the delta time phase with a zero tick count. After the byte with track_last
// the parser returns to that same state for the next track. Bytes after an
// end-of-track meta event are consumed without effect.
// The tick count saturates at its maximum; tick shows its low 32 bits.
`default_nettype none
module midi_track_meta_event_parser_core
  import mtmp_pkg::*;
#(
  parameter int unsigned TICK_WIDTH = 32
) (
  input  wire           clk,
  input  wire           rst,
  mtmp_byte_if.sink     byte_in,
  mtmp_event_if.source  event_out
);

  localparam int unsigned SUM_W = ((TICK_WIDTH > NUMBER_W) ? TICK_WIDTH : NUMBER_W) + 1;
  localparam logic [SUM_W-1:0] TICK_MAX = {{(SUM_W - TICK_WIDTH){1'b0}}, {TICK_WIDTH{1'b1}}};

  phase_t                phase, phase_next;
  logic [TICK_WIDTH-1:0] tick_count, tick_count_next;
  logic [NUMBER_W-1:0]   acc, acc_next;
  logic [7:0]            run_status, run_status_next;
  logic [7:0]            meta_kind, meta_kind_next;
  logic [NUMBER_W-1:0]   remaining, remaining_next;
  logic [7:0]            captured [4];
  logic [2:0]            cap_index, cap_index_next;

  event_t out_reg, skid_reg, evt;
  logic   out_valid, skid_valid;
  logic   emit;

  logic                accept, pop, push;
  logic [7:0]          b;
  logic [NUMBER_W-1:0] acc_shift;
  logic [SUM_W-1:0]    tick_sum, tick_sat, tick_ext;
  logic                meta_finish;
  logic [TEMPO_W-1:0]  tempo_val;

  assign b         = byte_in.data_byte;
  assign accept    = byte_in.valid && byte_in.ready;
  assign acc_shift = {acc[NUMBER_W-8:0], b[6:0]};
  assign tick_sum  = SUM_W'(tick_count) + SUM_W'(acc_shift);
  assign tick_sat  = (tick_sum > TICK_MAX) ? TICK_MAX : tick_sum;
  assign tick_ext  = SUM_W'(tick_count);
  assign tempo_val = {captured[0], captured[1], b};

  // The meta body ends on a zero length field or on its last data byte.
  assign meta_finish = ((phase == PH_META_LEN) && !b[7] && (acc_shift == '0)) ||
                       ((phase == PH_META_DATA) && (remaining == NUMBER_W'(1)));

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_DELTA: begin
        if (!b[7]) phase_next = PH_STATUS;
      end
      PH_STATUS: begin
        if (b == META_PREFIX) begin
          phase_next = PH_META_TYPE;
        end else if (b == SYSEX_START || b == SYSEX_ESCAPE) begin
          phase_next = PH_SYSEX_LEN;
        end else if (b[7]) begin
          phase_next = PH_SKIP;
        end else if (run_status == '0 || run_status[7:4] == STATUS_SYSTEM) begin
          phase_next = PH_DELTA;
        end else begin
          phase_next = (data_count(run_status) == 2'd1) ? PH_DELTA : PH_SKIP;
        end
      end
      PH_META_TYPE: phase_next = PH_META_LEN;
      PH_META_LEN, PH_META_DATA: begin
        if (meta_finish) begin
          phase_next = (meta_kind == META_EOT) ? PH_DONE : PH_DELTA;
        end else if (phase == PH_META_LEN && !b[7]) begin
          phase_next = PH_META_DATA;
        end
      end
      PH_SYSEX_LEN: begin
        if (!b[7]) phase_next = (acc_shift == '0) ? PH_DELTA : PH_SKIP;
      end
      PH_SKIP: begin
        if (remaining <= NUMBER_W'(1)) phase_next = PH_DELTA;
      end
      default: phase_next = phase;
    endcase
  end

  always_comb begin
    tick_count_next = tick_count;
    acc_next        = acc;
    run_status_next = run_status;
    meta_kind_next  = meta_kind;
    remaining_next  = remaining;
    cap_index_next  = cap_index;
    emit            = 1'b0;
    evt             = '0;
    evt.tick        = tick_ext[TICK_OUT_W-1:0];
    case (phase)
      PH_DELTA: begin
        acc_next = acc_shift;
        if (!b[7]) begin
          tick_count_next = tick_sat[TICK_WIDTH-1:0];
          acc_next        = '0;
        end
      end
      PH_STATUS: begin
        acc_next = '0;
        if (b == META_PREFIX) begin
          acc_next = '0;
        end else if (b == SYSEX_START || b == SYSEX_ESCAPE) begin
          run_status_next = '0;
        end else if (b[7]) begin
          run_status_next = b;
          remaining_next  = NUMBER_W'(data_count(b));
        end else if (run_status != '0 && run_status[7:4] != STATUS_SYSTEM) begin
          remaining_next = NUMBER_W'(data_count(run_status) - 2'd1);
        end
      end
      PH_META_TYPE: begin
        meta_kind_next = b;
        acc_next       = '0;
      end
      PH_META_LEN: begin
        acc_next = acc_shift;
        if (!b[7]) begin
          remaining_next  = acc_shift;
          acc_next        = '0;
          cap_index_next  = '0;
          run_status_next = '0;
        end
      end
      PH_META_DATA: begin
        if (cap_index != 3'd7) cap_index_next = cap_index + 3'd1;
        remaining_next = remaining - NUMBER_W'(1);
      end
      PH_SYSEX_LEN: begin
        acc_next = acc_shift;
        if (!b[7]) begin
          remaining_next = acc_shift;
          acc_next       = '0;
        end
      end
      PH_SKIP: begin
        if (remaining != '0) remaining_next = remaining - NUMBER_W'(1);
      end
      default: begin
        acc_next = acc;
      end
    endcase

    // A length-zero body leaves the capture count at zero, so nothing is reported.
    if (meta_finish) begin
      if (meta_kind == META_TEMPO && cap_index_next == 3'd3 && tempo_val != '0) begin
        emit                     = 1'b1;
        evt.event_kind           = EVT_TEMPO;
        evt.tempo_us_per_quarter = tempo_val;
      end else if (meta_kind == META_TIMESIG && cap_index_next == 3'd4) begin
        emit                     = 1'b1;
        evt.event_kind           = EVT_TIMESIG;
        evt.sig_numerator        = captured[0];
        evt.sig_denominator_log2 = captured[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_DELTA;
      tick_count <= '0;
      acc        <= '0;
      run_status <= '0;
      meta_kind  <= '0;
      remaining  <= '0;
      cap_index  <= '0;
    end else if (accept) begin
      if (byte_in.track_last) begin
        phase      <= PH_DELTA;
        tick_count <= '0;
        acc        <= '0;
        run_status <= '0;
        meta_kind  <= '0;
        remaining  <= '0;
        cap_index  <= '0;
      end else begin
        phase      <= phase_next;
        tick_count <= tick_count_next;
        acc        <= acc_next;
        run_status <= run_status_next;
        meta_kind  <= meta_kind_next;
        remaining  <= remaining_next;
        cap_index  <= cap_index_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && phase == PH_META_DATA && !cap_index[2]) begin
      captured[cap_index[1:0]] <= b;
    end
  end

  // Output register with a skid register behind it.
  assign push = accept && emit;
  assign pop  = out_valid && event_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_reg <= skid_valid ? skid_reg : evt;
    end else if (push) begin
      if (out_valid) begin
        skid_reg <= evt;
      end else begin
        out_reg <= evt;
      end
    end
  end

  assign byte_in.ready                  = !skid_valid;
  assign event_out.valid                = out_valid;
  assign event_out.event_kind           = out_reg.event_kind;
  assign event_out.tick                 = out_reg.tick;
  assign event_out.tempo_us_per_quarter = out_reg.tempo_us_per_quarter;
  assign event_out.sig_numerator        = out_reg.sig_numerator;
  assign event_out.sig_denominator_log2 = out_reg.sig_denominator_log2;

endmodule
`default_nettype wire

// ===== src/mtmp_checker.sv =====
// Port-level checks of the parser, attached to the parser core by bind.
`default_nettype none
module mtmp_checker
  import mtmp_pkg::*;
(
  input wire                  clk,
  input wire                  rst,
  input wire                  in_ready,
  input wire                  out_valid,
  input wire                  out_ready,
  input wire                  out_kind,
  input wire [TICK_OUT_W-1:0] out_tick,
  input wire [TEMPO_W-1:0]    out_tempo,
  input wire [7:0]            out_num,
  input wire [7:0]            out_den
);

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("event channel not empty after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_tick) &&
      $stable(out_tempo) && $stable(out_num) && $stable(out_den))
    else $error("stalled event request changed");

  a_tempo_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == EVT_TEMPO |-> out_tempo != '0 && out_num == '0 && out_den == '0)
    else $error("tempo event with bad fields");

  a_timesig_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == EVT_TIMESIG |-> out_tempo == '0)
    else $error("time signature event carries a tempo");

  a_backpressure_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("byte channel stalled with no event pending");

endmodule

bind midi_track_meta_event_parser_core mtmp_checker u_mtmp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (byte_in.ready),
  .out_valid (event_out.valid),
  .out_ready (event_out.ready),
  .out_kind  (event_out.event_kind),
  .out_tick  (event_out.tick),
  .out_tempo (event_out.tempo_us_per_quarter),
  .out_num   (event_out.sig_numerator),
  .out_den   (event_out.sig_denominator_log2)
);
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the MIDI track meta event parser core.
`timescale 1ns / 100ps
module testbench;
  import mtmp_pkg::*;

  localparam int unsigned TICK_BITS = 32;
  localparam logic [63:0] TICK_CEILING = (64'd1 << TICK_BITS) - 64'd1;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_BYTES = 1200;

  logic clk;
  logic rst;

  mtmp_byte_if  byte_ch ();
  mtmp_event_if event_ch ();

  midi_track_meta_event_parser_core #(
    .TICK_WIDTH(TICK_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .byte_in(byte_ch),
    .event_out(event_ch)
  );

  // Shadow of the parser state.
  phase_t      trk_phase;
  logic [63:0] trk_tick;
  logic [31:0] vlq_acc;
  logic [7:0]  run_status;
  logic [7:0]  meta_type;
  logic [31:0] left_bytes;
  logic [7:0]  meta_body [4];
  logic [2:0]  body_count;

  event_t      pending_events [$];
  logic [7:0]  track_q [$];

  int  cycle_count = 0;
  int  mismatch_count = 0;
  int  tempo_seen = 0;
  int  timesig_seen = 0;
  int  bytes_sent = 0;
  int  tracks_sent = 0;
  bit  tx_quiet = 0;
  bit  rx_quiet = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d events still expected",
               cycle_count, pending_events.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void clear_track();
    trk_phase  = PH_DELTA;
    trk_tick   = '0;
    vlq_acc    = '0;
    run_status = '0;
    meta_type  = '0;
    left_bytes = '0;
    body_count = '0;
    for (int i = 0; i < 4; i++) meta_body[i] = '0;
  endfunction

  function automatic int status_data_bytes(input logic [7:0] status);
    if (status[7:4] == STATUS_PROGRAM || status[7:4] == STATUS_PRESSURE ||
        status[7:4] == STATUS_SYSTEM) return 1;
    return 2;
  endfunction

  // Closes a meta event body and reports whether it yields an event.
  function automatic bit close_meta(output event_t ev);
    logic [23:0] us;
    bit got;
    got = 1'b0;
    ev = '0;
    us = {meta_body[0], meta_body[1], meta_body[2]};
    if (meta_type == META_TEMPO && body_count == 3'd3) begin
      if (us != '0) begin
        ev.event_kind = EVT_TEMPO;
        ev.tick = trk_tick[TICK_OUT_W-1:0];
        ev.tempo_us_per_quarter = us;
        got = 1'b1;
      end
    end else if (meta_type == META_TIMESIG && body_count == 3'd4) begin
      ev.event_kind = EVT_TIMESIG;
      ev.tick = trk_tick[TICK_OUT_W-1:0];
      ev.sig_numerator = meta_body[0];
      ev.sig_denominator_log2 = meta_body[1];
      got = 1'b1;
    end
    trk_phase = (meta_type == META_EOT) ? PH_DONE : PH_DELTA;
    return got;
  endfunction

  function automatic bit parse_track_byte(input logic [7:0] b, input bit is_last,
                                          output event_t ev);
    logic [63:0] sum;
    bit got;
    got = 1'b0;
    ev = '0;
    case (trk_phase)
      PH_DELTA: begin
        vlq_acc = {vlq_acc[24:0], b[6:0]};
        if (!b[7]) begin
          sum = trk_tick + {32'd0, vlq_acc};
          trk_tick = (sum > TICK_CEILING) ? TICK_CEILING : sum;
          vlq_acc = '0;
          trk_phase = PH_STATUS;
        end
      end
      PH_STATUS: begin
        vlq_acc = '0;
        if (b == META_PREFIX) begin
          trk_phase = PH_META_TYPE;
        end else if (b == SYSEX_START || b == SYSEX_ESCAPE) begin
          run_status = '0;
          trk_phase = PH_SYSEX_LEN;
        end else if (b[7]) begin
          run_status = b;
          left_bytes = status_data_bytes(b);
          trk_phase = PH_SKIP;
        end else if (run_status == '0 || run_status[7:4] == STATUS_SYSTEM) begin
          trk_phase = PH_DELTA;
        end else begin
          left_bytes = status_data_bytes(run_status) - 1;
          trk_phase = (left_bytes == '0) ? PH_DELTA : PH_SKIP;
        end
      end
      PH_META_TYPE: begin
        meta_type = b;
        vlq_acc = '0;
        trk_phase = PH_META_LEN;
      end
      PH_META_LEN: begin
        vlq_acc = {vlq_acc[24:0], b[6:0]};
        if (!b[7]) begin
          left_bytes = vlq_acc;
          vlq_acc = '0;
          body_count = '0;
          run_status = '0;
          if (left_bytes == '0) got = close_meta(ev);
          else trk_phase = PH_META_DATA;
        end
      end
      PH_META_DATA: begin
        if (body_count < 3'd4) meta_body[body_count[1:0]] = b;
        if (body_count < 3'd7) body_count = body_count + 3'd1;
        left_bytes = left_bytes - 1;
        if (left_bytes == '0) got = close_meta(ev);
      end
      PH_SYSEX_LEN: begin
        vlq_acc = {vlq_acc[24:0], b[6:0]};
        if (!b[7]) begin
          left_bytes = vlq_acc;
          vlq_acc = '0;
          trk_phase = (left_bytes == '0) ? PH_DELTA : PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (left_bytes != '0) left_bytes = left_bytes - 1;
        if (left_bytes == '0) trk_phase = PH_DELTA;
      end
      default: begin
      end
    endcase
    if (is_last) clear_track();
    return got;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Appends one byte to the track being built.
  task automatic queue_byte(input logic [7:0] b);
    track_q.insert(track_q.size(), b);
  endtask

  task automatic send_byte(input logic [7:0] b, input bit is_last);
    event_t ev;
    int gap;
    @(negedge clk);
    byte_ch.valid = 1'b1;
    byte_ch.data_byte = b;
    byte_ch.track_last = is_last;
    do @(posedge clk); while (!byte_ch.ready);
    if (parse_track_byte(b, is_last, ev)) pending_events.insert(pending_events.size(), ev);
    bytes_sent++;
    gap = tx_quiet ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk);
      byte_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic play_track();
    for (int i = 0; i < track_q.size(); i++) send_byte(track_q[i], i == track_q.size() - 1);
    track_q.delete();
    tracks_sent++;
  endtask

  // Variable-length quantity, occasionally with a redundant leading group.
  task automatic add_number(input logic [31:0] v);
    int n;
    n = 1;
    while (n < 5 && (v >> (7 * n)) != 0) n++;
    if ($urandom_range(0, 9) == 0) queue_byte(8'h80);
    for (int i = n - 1; i >= 0; i--) queue_byte({i != 0, 7'(v >> (7 * i))});
  endtask

  task automatic add_delta();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      add_number(0);
    end else if (r < 80) begin
      add_number($urandom_range(1, 127));
    end else if (r < 95) begin
      add_number($urandom_range(128, 32'hFFFFF));
    end else if (r < 99) begin
      add_number($urandom_range(32'h100000, 32'h0FFFFFFF));
    end else begin
      // Five groups: the top bits fall off and the tick count may saturate.
      repeat (4) queue_byte(8'($urandom_range(8'h80, 8'hFF)));
      queue_byte(8'($urandom_range(0, 8'h7F)));
    end
  endtask

  task automatic add_meta_head(input logic [7:0] kind, input logic [31:0] len);
    queue_byte(META_PREFIX);
    queue_byte(kind);
    add_number(len);
  endtask

  task automatic add_event();
    int r;
    int cnt;
    int len;
    logic [23:0] us;
    logic [7:0] status;
    logic [7:0] kind;
    r = $urandom_range(0, 99);
    add_delta();
    if (r < 25) begin
      case ($urandom_range(0, 15))
        0: us = '0;
        1: us = '1;
        default: us = 24'($urandom);
      endcase
      add_meta_head(META_TEMPO, 3);
      queue_byte(us[23:16]);
      queue_byte(us[15:8]);
      queue_byte(us[7:0]);
    end else if (r < 45) begin
      add_meta_head(META_TIMESIG, 4);
      repeat (4) queue_byte(8'($urandom));
    end else if (r < 55) begin
      case ($urandom_range(0, 3))
        0: kind = META_TEMPO;
        1: kind = META_TIMESIG;
        default: kind = 8'($urandom);
      endcase
      len = $urandom_range(0, 6);
      add_meta_head(kind, len);
      repeat (len) queue_byte(8'($urandom));
    end else if (r < 65) begin
      queue_byte($urandom_range(0, 1) ? SYSEX_START : SYSEX_ESCAPE);
      len = $urandom_range(0, 5);
      add_number(len);
      repeat (len) queue_byte(8'($urandom));
    end else if (r < 85) begin
      status = 8'($urandom_range(8'h80, 8'hEF));
      cnt = status_data_bytes(status);
      queue_byte(status);
      repeat (cnt) queue_byte(8'($urandom_range(0, 8'h7F)));
      // Further events under running status.
      repeat ($urandom_range(0, 3)) begin
        add_delta();
        repeat (cnt) queue_byte(8'($urandom_range(0, 8'h7F)));
      end
    end else if (r < 92) begin
      do status = 8'($urandom_range(8'hF1, 8'hFE)); while (status == SYSEX_ESCAPE);
      queue_byte(status);
      queue_byte(8'($urandom));
      if ($urandom_range(0, 1)) begin
        add_delta();
        queue_byte(8'($urandom_range(0, 8'h7F)));
      end
    end else begin
      queue_byte(8'($urandom));
    end
  endtask

  task automatic build_random_track();
    int r;
    repeat ($urandom_range(3, 12)) add_event();
    r = $urandom_range(0, 99);
    if (r < 65) begin
      add_delta();
      add_meta_head(META_EOT, 0);
      repeat ($urandom_range(0, 3)) queue_byte(8'($urandom));
    end else if (r >= 80) begin
      // Cut the track anywhere, often in the middle of an event.
      while (track_q.size() > 1 && $urandom_range(0, 3) != 0) void'(track_q.pop_back());
    end
  endtask

  task automatic test_extremes();
    // Five-group delta that saturates the tick, maximum tempo and signature,
    // then end of track followed by an ignored byte.
    track_q = '{8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h51, 8'h03, 8'hFF, 8'hFF,
                8'hFF, 8'h00, 8'hFF, 8'h58, 8'h04, 8'hFF, 8'hFF, 8'h18, 8'h08, 8'h00,
                8'hFF, 8'h2F, 8'h00, 8'h9C};
    play_track();
  endtask

  task automatic test_rejected_meta();
    // Zero tempo, a signature of the wrong length, a padded tempo length,
    // and a signature completed on the track's final byte.
    track_q = '{8'h00, 8'hFF, 8'h51, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h58,
                8'h03, 8'h04, 8'h02, 8'h18, 8'h00, 8'hFF, 8'h51, 8'h80, 8'h03, 8'h07,
                8'hA1, 8'h20, 8'h81, 8'h00, 8'hFF, 8'h58, 8'h04, 8'h03, 8'h03, 8'h0C,
                8'h08};
    play_track();
  endtask

  task automatic test_status_corners();
    // Data byte with no running status, system status with its skipped byte,
    // running status of a program change, a sysex block, a tempo event, and finally
    // a meta event whose huge length is cut off by the end of the track.
    track_q = '{8'h00, 8'h40, 8'h00, 8'hF3, 8'h7E, 8'h05, 8'h12, 8'h00, 8'hC5, 8'h33,
                8'h01, 8'h44, 8'h00, 8'hF0, 8'h02, 8'h11, 8'hF7, 8'h00, 8'hFF, 8'h51,
                8'h03, 8'h0F, 8'h42, 8'h40, 8'h02, 8'hFF, 8'h58, 8'hFF, 8'hFF, 8'hFF,
                8'hFF, 8'h7F, 8'h01, 8'h02};
    play_track();
  endtask

  task automatic test_random_tracks();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      build_random_track();
      play_track();
    end
    tx_quiet = 1'b0;
  endtask

  // Receiver: ready in bursts, with random stalls and quiet stretches.
  initial begin
    int stall;
    event_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      event_ch.ready = 1'b1;
      repeat ($urandom_range(1, 12) - 1) @(negedge clk);
      if ($urandom_range(0, 15) == 0) rx_quiet = !rx_quiet;
      stall = rx_quiet ? 0 : idle_len();
      if (stall > 0) begin
        @(negedge clk);
        event_ch.ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    event_t got;
    event_t want;
    if (!rst && event_ch.valid && event_ch.ready) begin
      got.event_kind = event_ch.event_kind;
      got.tick = event_ch.tick;
      got.tempo_us_per_quarter = event_ch.tempo_us_per_quarter;
      got.sig_numerator = event_ch.sig_numerator;
      got.sig_denominator_log2 = event_ch.sig_denominator_log2;
      if (pending_events.size() == 0) begin
        if (mismatch_count < 10)
          $display("Unexpected event at cycle %0d: kind=%0d tick=%0h", cycle_count,
                   got.event_kind, got.tick);
        mismatch_count++;
      end else begin
        want = pending_events.pop_front();
        if (got.event_kind !== want.event_kind || got.tick !== want.tick ||
            got.tempo_us_per_quarter !== want.tempo_us_per_quarter ||
            got.sig_numerator !== want.sig_numerator ||
            got.sig_denominator_log2 !== want.sig_denominator_log2) begin
          if (mismatch_count < 10) begin
            $display("Mismatch at cycle %0d", cycle_count);
            $display("  expected kind=%0d tick=%0h tempo=%0h num=%0d den=%0d",
                     want.event_kind, want.tick, want.tempo_us_per_quarter,
                     want.sig_numerator, want.sig_denominator_log2);
            $display("  actual   kind=%0d tick=%0h tempo=%0h num=%0d den=%0d",
                     got.event_kind, got.tick, got.tempo_us_per_quarter,
                     got.sig_numerator, got.sig_denominator_log2);
          end
          mismatch_count++;
        end
        if (want.event_kind == EVT_TEMPO) tempo_seen++;
        else timesig_seen++;
      end
    end
  end

  initial begin
    rst = 1'b1;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.track_last = 1'b0;
    clear_track();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_extremes();
    test_rejected_meta();
    test_status_corners();
    test_random_tracks();

    @(negedge clk);
    byte_ch.valid = 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d tracks, %0d bytes; checked %0d tempo and %0d time signature events.",
             tracks_sent, bytes_sent, tempo_seen, timesig_seen);
    $display("Tracks mixed saturating ticks, long numbers, running and system status,");
    $display("sysex, rejected meta events and truncated endings. %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0 && pending_events.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/mtmp_pkg.sv
src/mtmp_byte_if.sv
src/mtmp_event_if.sv
src/midi_track_meta_event_parser_core.sv
src/mtmp_checker.sv
sim/testbench.sv
